/* hdl/timer_deadline_queue_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define TDQ_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Implication checked in the cycle after the antecedent.
`define TDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

/* hdl/tdq_pkg.sv */
// ----------------------------------------------------------------------------
// tdq_pkg
// Types and constants shared by the timer deadline queue modules.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 64;
    localparam int PER_W     = 32;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REFRESH = 3'd2,
        OP_RESET   = 3'd3,
        OP_EXPIRE  = 3'd4,
        OP_QUERY   = 3'd5
    } tdq_op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INACTIVE = 3'd1,
        ST_FULL     = 3'd2,
        ST_EXPIRED  = 3'd3,
        ST_NONE_DUE = 3'd4
    } tdq_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RST2,
        S_FRONT,
        S_FRONT_FIN,
        S_DUE,
        S_ESCAN,
        S_EEMIT,
        S_QSCAN,
        S_QFIN
    } tdq_state_t;

    typedef struct packed {
        logic                 we_act;
        logic                 act_val;
        logic                 we_rec;
        logic                 rec_val;
        logic                 we_per;
        logic                 we_dl;
        logic [SLOT_W-1:0]    idx;
        logic [PER_W-1:0]     per;
        logic [TIME_W-1:0]    dl;
    } tdq_wr_t;

endpackage

/* hdl/tdq_table.sv */
// ----------------------------------------------------------------------------
// tdq_table
// Slot storage: active and recurring marks, periods and deadlines.
// ----------------------------------------------------------------------------
module tdq_table
    import tdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdq_wr_t               wr,
    input  logic [SLOT_W-1:0]     rd_idx,
    output logic [PER_W-1:0]      rd_per,
    output logic [TIME_W-1:0]     rd_dl,
    output logic [NUM_SLOTS-1:0]  active,
    output logic [NUM_SLOTS-1:0]  rec
);

    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] rec_reg;
    logic [PER_W-1:0]     per_mem [NUM_SLOTS];
    logic [TIME_W-1:0]    dl_mem  [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            rec_reg    <= '0;
        end
        else
        begin
            if (wr.we_act)
            begin
                active_reg[wr.idx] <= wr.act_val;
            end
            if (wr.we_rec)
            begin
                rec_reg[wr.idx] <= wr.rec_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we_per)
        begin
            per_mem[wr.idx] <= wr.per;
        end
        if (wr.we_dl)
        begin
            dl_mem[wr.idx] <= wr.dl;
        end
    end

    assign rd_per = per_mem[rd_idx];
    assign rd_dl  = dl_mem[rd_idx];
    assign active = active_reg;
    assign rec    = rec_reg;

endmodule

/* hdl/timer_deadline_queue_unit.sv */
// Full-table add, cancel, refresh, unknown codes and a reset that changes nothing: result
// straight from the execute state. Add with a free slot and a reset that changes the timer
// also run the front scan. Query: a slot scan. Expire: the due scan, then a scan per due timer.
// The slot scans share one 64-bit adder and comparator on a single table port; the receiver
// cannot stall, and a new command is taken once the last result of the previous one is out.
// Reset clears all slots to inactive and the front notification to pending-free.
// ----------------------------------------------------------------------------
// timer_deadline_queue_unit
// Ordered timer queue with a sequenced scan over the slot table.
// ----------------------------------------------------------------------------
module timer_deadline_queue_unit
    import tdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         operation,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic [SLOT_W-1:0]  timer_id,
    input  logic [PER_W-1:0]   period_ms,
    input  logic               recurring,
    input  logic               restart_now,
    output logic               busy,
    output logic               done,
    output logic [2:0]         status,
    output logic [SLOT_W-1:0]  slot_id,
    output logic [TIME_W-1:0]  wait_ms,
    output logic               any_active,
    output logic               front_notify,
    output logic               last
);

    tdq_state_t           state_reg, state_next;
    tdq_op_t              op_reg, op_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [SLOT_W-1:0]    id_reg, id_next;
    logic [PER_W-1:0]     per_reg, per_next;
    logic                 rec_in_reg, rec_in_next;
    logic                 fnow_reg, fnow_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]    tgt_reg, tgt_next;
    logic [TIME_W-1:0]    tgt_dl_reg, tgt_dl_next;
    logic [TIME_W-1:0]    tmp_reg, tmp_next;
    logic [SLOT_W-1:0]    best_reg, best_next;
    logic [TIME_W-1:0]    best_dl_reg, best_dl_next;
    logic                 found_reg, found_next;
    logic                 front_ok_reg, front_ok_next;
    logic [NUM_SLOTS-1:0] due_reg, due_next;
    logic                 aa_reg, aa_next;
    logic                 fn_reg, fn_next;

    logic                 done_reg, done_next;
    logic [2:0]           status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TIME_W-1:0]    wait_reg, wait_next;
    logic                 front_reg, front_next;
    logic                 last_reg, last_next;
    logic                 use_aa_reg, use_aa_next;

    tdq_wr_t              wr;
    logic [SLOT_W-1:0]    rd_idx;
    logic [PER_W-1:0]     rd_per;
    logic [TIME_W-1:0]    rd_dl;
    logic [NUM_SLOTS-1:0] active;
    logic [NUM_SLOTS-1:0] rec;

    // Shared arithmetic: one adder with carry in, one comparator.
    logic [TIME_W-1:0]    add_a, add_b, sum;
    logic                 add_cin;
    logic [TIME_W-1:0]    cmp_key;
    logic                 cmp_lt, cmp_eq;

    logic                 scan_end;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_slot;
    logic [NUM_SLOTS-1:0] best_mask;
    logic [NUM_SLOTS-1:0] due_left;

    tdq_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd_per (rd_per),
        .rd_dl  (rd_dl),
        .active (active),
        .rec    (rec)
    );

    assign sum      = add_a + add_b + {{(TIME_W-1){1'b0}}, add_cin};
    assign cmp_lt   = rd_dl < cmp_key;
    assign cmp_eq   = rd_dl == cmp_key;
    assign scan_end = idx_reg == SLOT_W'(NUM_SLOTS - 1);

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!active[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign best_mask = NUM_SLOTS'(1) << best_reg;
    assign due_left  = due_reg & ~best_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            fn_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            fn_reg    <= fn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        id_reg       <= id_next;
        per_reg      <= per_next;
        rec_in_reg   <= rec_in_next;
        fnow_reg     <= fnow_next;
        idx_reg      <= idx_next;
        tgt_reg      <= tgt_next;
        tgt_dl_reg   <= tgt_dl_next;
        tmp_reg      <= tmp_next;
        best_reg     <= best_next;
        best_dl_reg  <= best_dl_next;
        found_reg    <= found_next;
        front_ok_reg <= front_ok_next;
        due_reg      <= due_next;
        aa_reg       <= aa_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        wait_reg     <= wait_next;
        front_reg    <= front_next;
        last_reg     <= last_next;
        use_aa_reg   <= use_aa_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        state_next = free_found ? S_FRONT : S_IDLE;
                    end
                    OP_RESET:
                    begin
                        if ((per_reg != rd_per || fnow_reg) && active[id_reg])
                        begin
                            state_next = S_RST2;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    OP_EXPIRE:  state_next = S_DUE;
                    OP_QUERY:   state_next = S_QSCAN;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_RST2:      state_next = S_FRONT;
            S_FRONT:     state_next = scan_end ? S_FRONT_FIN : S_FRONT;
            S_FRONT_FIN: state_next = S_IDLE;
            S_DUE:
            begin
                if (scan_end)
                begin
                    if ((due_reg | (NUM_SLOTS'(active[idx_reg] && !cmp_lt && !cmp_eq
                        ? 1'b0 : active[idx_reg]) << idx_reg)) == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ESCAN;
                    end
                end
            end
            S_ESCAN:     state_next = scan_end ? S_EEMIT : S_ESCAN;
            S_EEMIT:     state_next = (due_left == '0) ? S_IDLE : S_ESCAN;
            S_QSCAN:     state_next = scan_end ? S_QFIN : S_QSCAN;
            S_QFIN:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        op_next       = op_reg;
        now_next      = now_reg;
        id_next       = id_reg;
        per_next      = per_reg;
        rec_in_next   = rec_in_reg;
        fnow_next     = fnow_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        tgt_dl_next   = tgt_dl_reg;
        tmp_next      = tmp_reg;
        best_next     = best_reg;
        best_dl_next  = best_dl_reg;
        found_next    = found_reg;
        front_ok_next = front_ok_reg;
        due_next      = due_reg;
        aa_next       = aa_reg;
        fn_next       = fn_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        slot_next     = slot_reg;
        wait_next     = wait_reg;
        front_next    = front_reg;
        last_next     = last_reg;
        use_aa_next   = use_aa_reg;
        wr            = '0;
        rd_idx        = idx_reg;
        add_a         = now_reg;
        add_b         = {{(TIME_W-PER_W){1'b0}}, per_reg};
        add_cin       = 1'b0;
        cmp_key       = best_dl_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = tdq_op_t'(operation);
                    now_next    = now_ms;
                    id_next     = timer_id;
                    per_next    = period_ms;
                    rec_in_next = recurring;
                    fnow_next   = restart_now;
                end
            end
            S_EXEC:
            begin
                rd_idx      = id_reg;
                status_next = ST_OK;
                slot_next   = '0;
                wait_next   = '0;
                front_next  = 1'b0;
                last_next   = 1'b1;
                use_aa_next = 1'b0;
                idx_next    = '0;
                found_next  = 1'b0;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (free_found)
                        begin
                            wr.we_act     = 1'b1;
                            wr.act_val    = 1'b1;
                            wr.we_rec     = 1'b1;
                            wr.rec_val    = rec_in_reg;
                            wr.we_per     = 1'b1;
                            wr.we_dl      = 1'b1;
                            wr.idx        = free_slot;
                            wr.per        = per_reg;
                            wr.dl         = sum;
                            tgt_next      = free_slot;
                            tgt_dl_next   = sum;
                            front_ok_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            done_next   = 1'b1;
                        end
                    end
                    OP_CANCEL, OP_REFRESH:
                    begin
                        add_b = {{(TIME_W-PER_W){1'b0}}, rd_per};
                        if (!active[id_reg])
                        begin
                            status_next = ST_INACTIVE;
                        end
                        else if (op_reg == OP_CANCEL)
                        begin
                            wr.we_act = 1'b1;
                            wr.idx    = id_reg;
                        end
                        else
                        begin
                            wr.we_dl = 1'b1;
                            wr.idx   = id_reg;
                            wr.dl    = sum;
                        end
                        done_next = 1'b1;
                    end
                    OP_RESET:
                    begin
                        // Start point: now, or old deadline minus old period.
                        add_a   = rd_dl;
                        add_b   = ~{{(TIME_W-PER_W){1'b0}}, rd_per};
                        add_cin = 1'b1;
                        tmp_next = fnow_reg ? now_reg : sum;
                        if (per_reg == rd_per && !fnow_reg)
                        begin
                            done_next = 1'b1;
                        end
                        else if (!active[id_reg])
                        begin
                            status_next = ST_INACTIVE;
                            done_next   = 1'b1;
                        end
                    end
                    OP_EXPIRE:
                    begin
                        due_next = '0;
                    end
                    OP_QUERY:
                    begin
                        fn_next = 1'b0;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            S_RST2:
            begin
                add_a         = tmp_reg;
                wr.we_per     = 1'b1;
                wr.we_dl      = 1'b1;
                wr.idx        = id_reg;
                wr.per        = per_reg;
                wr.dl         = sum;
                tgt_next      = id_reg;
                tgt_dl_next   = sum;
                front_ok_next = 1'b1;
            end
            S_FRONT:
            begin
                cmp_key  = tgt_dl_reg;
                idx_next = idx_reg + SLOT_W'(1);
                if (idx_reg != tgt_reg && active[idx_reg] &&
                    (cmp_lt || (cmp_eq && idx_reg < tgt_reg)))
                begin
                    front_ok_next = 1'b0;
                end
            end
            S_FRONT_FIN:
            begin
                front_next  = front_ok_reg && !fn_reg;
                fn_next     = fn_reg || front_ok_reg;
                slot_next   = (op_reg == OP_ADD) ? tgt_reg : '0;
                status_next = ST_OK;
                done_next   = 1'b1;
            end
            S_DUE:
            begin
                cmp_key  = now_reg;
                idx_next = idx_reg + SLOT_W'(1);
                if (active[idx_reg] && (cmp_lt || cmp_eq))
                begin
                    due_next[idx_reg] = 1'b1;
                end
                if (scan_end)
                begin
                    // Every due timer is emitted, so the final active set is known now.
                    aa_next     = |(active & ~(due_next & ~rec));
                    use_aa_next = 1'b1;
                    found_next  = 1'b0;
                    if (due_next == '0)
                    begin
                        status_next = ST_NONE_DUE;
                        use_aa_next = 1'b0;
                        done_next   = 1'b1;
                    end
                end
            end
            S_ESCAN:
            begin
                idx_next = idx_reg + SLOT_W'(1);
                if (due_reg[idx_reg] && (!found_reg || cmp_lt))
                begin
                    found_next   = 1'b1;
                    best_next    = idx_reg;
                    best_dl_next = rd_dl;
                end
            end
            S_EEMIT:
            begin
                rd_idx      = best_reg;
                add_b       = {{(TIME_W-PER_W){1'b0}}, rd_per};
                wr.idx      = best_reg;
                wr.dl       = sum;
                wr.we_dl    = rec[best_reg];
                wr.we_act   = !rec[best_reg];
                due_next    = due_left;
                found_next  = 1'b0;
                idx_next    = '0;
                status_next = ST_EXPIRED;
                slot_next   = best_reg;
                last_next   = due_left == '0;
                done_next   = 1'b1;
            end
            S_QSCAN:
            begin
                idx_next = idx_reg + SLOT_W'(1);
                if (active[idx_reg] && (!found_reg || cmp_lt))
                begin
                    found_next   = 1'b1;
                    best_dl_next = rd_dl;
                end
            end
            S_QFIN:
            begin
                add_a   = best_dl_reg;
                add_b   = ~now_reg;
                add_cin = 1'b1;
                if (!found_reg)
                begin
                    wait_next = '1;
                end
                else if (now_reg >= best_dl_reg)
                begin
                    wait_next = '0;
                end
                else
                begin
                    wait_next = sum;
                end
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_id      = slot_reg;
    assign wait_ms      = wait_reg;
    assign front_notify = front_reg;
    assign last         = last_reg;
    assign any_active   = use_aa_reg ? aa_reg : (|active);

endmodule

/* hdl/tdq_checker.sv */
// ----------------------------------------------------------------------------
// tdq_checker
// Port-level checks on the result stream of the timer queue.
// ----------------------------------------------------------------------------
`include "timer_deadline_queue_unit_assert.svh"

module tdq_checker
    import tdq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [2:0]         status,
    input logic [SLOT_W-1:0]  slot_id,
    input logic [TIME_W-1:0]  wait_ms,
    input logic               front_notify,
    input logic               last
);

    `TDQ_ASSERT_IMPLY(a_none_due_last, done && status == ST_NONE_DUE, last)
    `TDQ_ASSERT_IMPLY(a_full_slot, done && status == ST_FULL, slot_id == '0 && last)
    `TDQ_ASSERT_IMPLY(a_front_ok, done && front_notify, status == ST_OK && last)
    `TDQ_ASSERT_IMPLY(a_wait_ok, done && wait_ms != '0, status == ST_OK)
    `TDQ_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)

endmodule

bind timer_deadline_queue_unit tdq_checker u_tdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .slot_id      (slot_id),
    .wait_ms      (wait_ms),
    .front_notify (front_notify),
    .last         (last)
);
